// ===== rtl/filtered_keyed_miss_counter_macros.svh =====
// Assertion macros for the filtered keyed miss counter.
// Expect signals aclk and aresetn in the scope of use.
`ifndef FILTERED_KEYED_MISS_COUNTER_MACROS_SVH
`define FILTERED_KEYED_MISS_COUNTER_MACROS_SVH

// same-cycle implication
`define FKMC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FKMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fkmc_pkg.sv =====
// Shared types and constants for the filtered keyed miss counter.
// No dependencies.
`default_nettype none
package fkmc_pkg;
    localparam int ENTRIES_DEF  = 1024;
    localparam int CPU_BITS_DEF = 12;
    localparam logic [31:0] ANY_CPU = 32'hFFFF_FFFF;
    localparam int CFG_IDX_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROCESS = 8'd0,
        REG_THREAD  = 8'd1,
        REG_CPU     = 8'd2,
        REG_BANK    = 8'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_FILTERED = 2'd0,
        ST_HIT      = 2'd1,
        ST_NEW      = 2'd2,
        ST_DROP     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_SCAN, S_HIT, S_MISS, S_DONE
    } state_t;

    typedef struct packed {
        logic pass;
        logic bank;
    } filt_t;
endpackage
`default_nettype wire

// ===== rtl/fkmc_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module fkmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== rtl/fkmc_cfg.sv =====
// Configuration registers and event filter check.
// Depends on fkmc_pkg.
`default_nettype none
module fkmc_cfg #(
    parameter int CPU_BITS = 12
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [fkmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                     cfg_data,
    input  wire logic [31:0]                     ev_process,
    input  wire logic [31:0]                     ev_thread,
    input  wire logic [CPU_BITS-1:0]             ev_cpu,
    output fkmc_pkg::filt_t                      filt
);
    import fkmc_pkg::*;

    logic [31:0] proc_reg, thr_reg, cpu_reg;
    logic        bank_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            proc_reg <= '0;
            thr_reg  <= '0;
            cpu_reg  <= ANY_CPU;
            bank_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PROCESS: proc_reg <= cfg_data;
                REG_THREAD:  thr_reg  <= cfg_data;
                REG_CPU:     cpu_reg  <= cfg_data;
                REG_BANK:    bank_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        filt.bank = bank_reg;
        filt.pass = !((proc_reg != '0 && ev_process != proc_reg) ||
                      (thr_reg != '0 && ev_thread != thr_reg) ||
                      (cpu_reg != ANY_CPU && 32'(ev_cpu) != cpu_reg));
    end
endmodule
`default_nettype wire

// ===== rtl/filtered_keyed_miss_counter.sv =====
// Top level of the filtered keyed miss counter: control FSM, key scan, counters.
// Depends on fkmc_pkg, fkmc_cfg, fkmc_ram and the assertion macro header.
//
// Usage: each item on the s_axis channel is one cache-miss event; tdata holds
// process id, thread id and cpu, tuser the miss kind. Each accepted item gives
// exactly one result item on m_axis: tuser carries the status, tdata the key's
// L1 and LLC counts and the global drop total.
// Configuration writes go over the cfg channel (always ready); write them only
// while idle, the block itself does not enforce it. Keys of the active bank
// are kept in fill order in one RAM; the lookup walks the filled entries one RAM
// read per cycle. The time an item takes grows with occ, the active bank's key
// count: a filtered event and a new key in an empty bank skip the scan, while a
// new key or a drop reads every filled entry.
// One item is in work at a time; the next is accepted while the previous
// result still waits in the output register. If the receiver stalls, the
// block holds the finished result of the next item until the output frees.
// Reset (synchronous, active low) empties both banks at once by zeroing the
// fill counts; no clearing pass is needed, and the drop counter clears.
`default_nettype none
`include "filtered_keyed_miss_counter_macros.svh"
module filtered_keyed_miss_counter #(
    parameter int ENTRIES  = fkmc_pkg::ENTRIES_DEF,
    parameter int CPU_BITS = fkmc_pkg::CPU_BITS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // process_id, thread_id, cpu_id, zero pad
    input  wire logic [((64+CPU_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // miss_kind
    input  wire logic                                 s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // l1_count, llc_count, drop_total
    output logic [191:0]                              m_axis_tdata,
    // status
    output logic [1:0]                                m_axis_tuser,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [fkmc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [31:0]                          cfg_data
);
    import fkmc_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES + 1);
    localparam int ADDR_W = $clog2(2 * ENTRIES);
    localparam int KEY_W  = 64 + CPU_BITS;
    localparam int RAM_W  = KEY_W + 128;

    state_t state_reg, state_next;

    logic [31:0]         ev_proc_reg, ev_thr_reg;
    logic [CPU_BITS-1:0] ev_cpu_reg;
    logic                ev_kind_reg;

    logic [IDX_W-1:0]    occ_reg [2];
    logic [63:0]         drops_reg;
    logic [IDX_W-1:0]    issue_idx_reg, rd_idx_reg, slot_reg;
    logic                rd_vld_reg;
    logic [63:0]         cnt_l1_reg, cnt_llc_reg;

    status_t             res_status_reg;
    logic [63:0]         res_l1_reg, res_llc_reg;
    logic                m_valid_reg;
    logic [191:0]        m_data_reg;
    status_t             m_status_reg;

    filt_t               filt;
    logic [IDX_W-1:0]    occ;
    logic                bank_full, issue, match, scan_end, out_free;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr, base_addr;
    logic [IDX_W-1:0]    ram_idx;
    logic [RAM_W-1:0]    ram_wdata, ram_rdata;
    logic [KEY_W-1:0]    ev_key;

    fkmc_cfg #(.CPU_BITS(CPU_BITS)) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .ev_process (ev_proc_reg),
        .ev_thread  (ev_thr_reg),
        .ev_cpu     (ev_cpu_reg),
        .filt       (filt)
    );

    fkmc_ram #(.WIDTH(RAM_W), .DEPTH(2 * ENTRIES)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_status_reg;

    assign occ       = occ_reg[filt.bank];
    assign bank_full = (occ == IDX_W'(ENTRIES));
    assign ev_key    = {ev_cpu_reg, ev_thr_reg, ev_proc_reg};
    assign issue     = (state_reg == S_SCAN) && (issue_idx_reg < occ);
    // read data lines up with rd_vld_reg / rd_idx_reg
    assign match     = rd_vld_reg && (ram_rdata[KEY_W-1:0] == ev_key);
    assign scan_end  = rd_vld_reg && !match && (rd_idx_reg == occ - IDX_W'(1));
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign base_addr = filt.bank ? ADDR_W'(ENTRIES) : '0;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_axis_tvalid) state_next = S_CHECK;
            S_CHECK: begin
                if (!filt.pass)       state_next = S_DONE;
                else if (occ == '0)   state_next = S_MISS;
                else                  state_next = S_SCAN;
            end
            S_SCAN: begin
                if (match)            state_next = S_HIT;
                else if (scan_end)    state_next = S_MISS;
            end
            S_HIT:   state_next = S_DONE;
            S_MISS:  state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // RAM control
    always_comb begin
        ram_we    = 1'b0;
        ram_idx   = issue_idx_reg;
        ram_wdata = {cnt_llc_reg + 64'(ev_kind_reg),
                     cnt_l1_reg + 64'(!ev_kind_reg), ev_key};
        case (state_reg)
            S_HIT: begin
                ram_we  = 1'b1;
                ram_idx = slot_reg;
            end
            S_MISS: begin
                ram_we    = !bank_full;
                ram_idx   = occ;
                ram_wdata = {64'(ev_kind_reg), 64'(!ev_kind_reg), ev_key};
            end
            default: ;
        endcase
        ram_addr = base_addr + ADDR_W'(ram_idx);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            occ_reg[0]  <= '0;
            occ_reg[1]  <= '0;
            drops_reg   <= '0;
            m_valid_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == S_DONE) && out_free) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_axis_tready) m_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE: begin
                    ev_proc_reg <= s_axis_tdata[31:0];
                    ev_thr_reg  <= s_axis_tdata[63:32];
                    ev_cpu_reg  <= s_axis_tdata[64 +: CPU_BITS];
                    ev_kind_reg <= s_axis_tuser;
                end
                S_CHECK: begin
                    issue_idx_reg  <= '0;
                    rd_vld_reg     <= 1'b0;
                    res_status_reg <= ST_FILTERED;
                    res_l1_reg     <= '0;
                    res_llc_reg    <= '0;
                end
                S_SCAN: begin
                    rd_vld_reg <= issue;
                    rd_idx_reg <= issue_idx_reg;
                    if (issue) issue_idx_reg <= issue_idx_reg + IDX_W'(1);
                    if (match) begin
                        slot_reg    <= rd_idx_reg;
                        cnt_l1_reg  <= ram_rdata[KEY_W +: 64];
                        cnt_llc_reg <= ram_rdata[KEY_W+64 +: 64];
                    end
                end
                S_HIT: begin
                    res_status_reg <= ST_HIT;
                    res_l1_reg     <= cnt_l1_reg + 64'(!ev_kind_reg);
                    res_llc_reg    <= cnt_llc_reg + 64'(ev_kind_reg);
                end
                S_MISS: begin
                    if (bank_full) begin
                        drops_reg      <= drops_reg + 64'd1;
                        res_status_reg <= ST_DROP;
                    end else begin
                        occ_reg[filt.bank] <= occ + IDX_W'(1);
                        res_status_reg     <= ST_NEW;
                        res_l1_reg         <= 64'(!ev_kind_reg);
                        res_llc_reg        <= 64'(ev_kind_reg);
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        m_status_reg <= res_status_reg;
                        m_data_reg   <= {drops_reg, res_llc_reg, res_l1_reg};
                    end
                end
                default: ;
            endcase
        end
    end

    `FKMC_ASSERT_IMPL(a_occ_bound, 1'b1, (occ_reg[0] <= IDX_W'(ENTRIES)) && (occ_reg[1] <= IDX_W'(ENTRIES)), "bank occupancy above capacity")
    `FKMC_ASSERT_IMPL(a_we_state, ram_we, (state_reg == S_HIT) || (state_reg == S_MISS), "RAM write outside update")
    `FKMC_ASSERT_NEXT(a_drop_inc, (state_reg == S_MISS) && bank_full, drops_reg == $past(drops_reg) + 64'd1, "drop counter did not advance")
    `FKMC_ASSERT_NEXT(a_hold_out, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
endmodule
`default_nettype wire

// ===== dv/tb_filtered_keyed_miss_counter.sv =====
// Testbench for the filtered keyed miss counter: drives miss events and config
// writes, predicts each result with a local key table and checks it field by field.
// Depends on fkmc_pkg and the filtered_keyed_miss_counter RTL.
`default_nettype none

class miss_count_board;
    localparam int NENT = 1024;
    bit [31:0] proc_filt;
    bit [31:0] thr_filt;
    bit [31:0] cpu_filt;
    bit        bank_sel;
    bit [75:0] keys [2][$];
    bit [63:0] l1_cnt [2][$];
    bit [63:0] llc_cnt [2][$];
    bit [63:0] drop_cnt;
    bit [1:0]  exp_status [$];
    bit [191:0] exp_counts [$];
    int        errors;

    function new();
        proc_filt = 0;
        thr_filt = 0;
        cpu_filt = fkmc_pkg::ANY_CPU;
        bank_sel = 0;
        drop_cnt = 0;
        errors = 0;
    endfunction

    function void write_reg(fkmc_pkg::reg_idx_t idx, bit [31:0] val);
        case (idx)
            fkmc_pkg::REG_PROCESS: proc_filt = val;
            fkmc_pkg::REG_THREAD:  thr_filt = val;
            fkmc_pkg::REG_CPU:     cpu_filt = val;
            fkmc_pkg::REG_BANK:    bank_sel = val[0];
            default: ;
        endcase
    endfunction

    function void note_event(bit [31:0] pid, bit [31:0] tid, bit [11:0] cpu, bit llc);
        bit [75:0] key;
        int slot;
        bit [1:0] st;
        key = {pid, tid, cpu};
        slot = -1;
        if ((proc_filt != 0 && pid != proc_filt) || (thr_filt != 0 && tid != thr_filt) ||
            (cpu_filt != fkmc_pkg::ANY_CPU && {20'd0, cpu} != cpu_filt)) begin
            exp_status.push_back(fkmc_pkg::ST_FILTERED);
            exp_counts.push_back({drop_cnt, 64'd0, 64'd0});
            return;
        end
        for (int i = 0; i < keys[bank_sel].size(); i++)
            if (slot < 0 && keys[bank_sel][i] == key) slot = i;
        if (slot >= 0) begin
            st = fkmc_pkg::ST_HIT;
        end else if (keys[bank_sel].size() < NENT) begin
            keys[bank_sel].push_back(key);
            l1_cnt[bank_sel].push_back(0);
            llc_cnt[bank_sel].push_back(0);
            slot = keys[bank_sel].size() - 1;
            st = fkmc_pkg::ST_NEW;
        end else begin
            drop_cnt++;
            exp_status.push_back(fkmc_pkg::ST_DROP);
            exp_counts.push_back({drop_cnt, 64'd0, 64'd0});
            return;
        end
        if (llc) llc_cnt[bank_sel][slot]++;
        else l1_cnt[bank_sel][slot]++;
        exp_status.push_back(st);
        exp_counts.push_back({drop_cnt, llc_cnt[bank_sel][slot], l1_cnt[bank_sel][slot]});
    endfunction

    function void check_result(bit [1:0] st, bit [191:0] counts);
        bit [1:0] est;
        bit [191:0] ec;
        if (exp_status.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: unexpected result status=%0d", st);
            return;
        end
        est = exp_status.pop_front();
        ec = exp_counts.pop_front();
        if (st != est || counts != ec) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: status %0d/%0d l1 %0h/%0h llc %0h/%0h drops %0h/%0h (exp/act)",
                         est, st, ec[63:0], counts[63:0], ec[127:64], counts[127:64],
                         ec[191:128], counts[191:128]);
        end
    endfunction
endclass

module tb_filtered_keyed_miss_counter;
    import fkmc_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata;   // process_id, thread_id, cpu_id, zero pad
    logic         s_axis_tuser;   // miss_kind
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [191:0] m_axis_tdata;   // l1_count, llc_count, drop_total
    logic [1:0]   m_axis_tuser;   // status
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_index;
    logic [31:0]  cfg_data;

    miss_count_board board;
    int  cycles = 0;
    bit  long_hold;
    bit  stall_free;

    filtered_keyed_miss_counter dut (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // generous: every item may scan a full bank
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 6000000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge aclk)
        if (aresetn && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tuser, m_axis_tdata);

    // receiver stall pattern; long_hold forces a long back-pressure stretch
    always @(posedge aclk) begin
        if (!aresetn || long_hold) m_axis_tready <= 1'b0;
        else if (stall_free) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 9) < 7);
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_event(logic [31:0] pid, logic [31:0] tid, logic [11:0] cpu, bit llc);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, cpu, tid, pid};
        s_axis_tuser <= llc;
        do @(posedge aclk); while (!s_axis_tready);
        board.note_event(pid, tid, cpu, llc);
    endtask

    task automatic pause_sender();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge aclk);
    endtask

    // waits until every result is back, then idles before the next phase
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.exp_status.size() != 0) @(posedge aclk);
        repeat (1100) @(posedge aclk);
    endtask

    // random events over a small key pool so hits dominate
    task automatic random_burst(int n, int pool);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, pool - 1);
            if ($urandom_range(0, 7) == 0)
                send_event($urandom, $urandom, 12'($urandom), 1'($urandom));
            else
                send_event(32'(32'h100 + k % 5), 32'(32'h200 + k), 12'(k % 4),
                           1'($urandom));
            if ($urandom_range(0, 9) == 0) pause_sender();
        end
    endtask

    initial begin
        board = new();
        long_hold = 0;
        stall_free = 0;
        aresetn = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = 0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: field extremes, hit/new, both miss kinds
        send_event(0, 0, 0, 0);
        send_event(0, 0, 0, 1);
        send_event(32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 1);
        send_event(32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 0);
        send_event(32'h5555_5555, 32'hAAAA_AAAA, 12'h555, 0);
        send_event(32'hAAAA_AAAA, 32'h5555_5555, 12'hAAA, 1);
        drain();
        write_reg(REG_PROCESS, 32'h1234);
        write_reg(REG_THREAD, 32'h77);
        write_reg(REG_CPU, 32'd3);
        send_event(32'h1234, 32'h77, 3, 0);
        send_event(32'h1235, 32'h77, 3, 0);
        send_event(32'h1234, 32'h76, 3, 1);
        send_event(32'h1234, 32'h77, 4, 1);
        drain();
        // cpu filter no cpu can match
        write_reg(REG_CPU, 32'h0001_0000);
        send_event(32'h1234, 32'h77, 0, 0);
        send_event(32'h1234, 32'h77, 12'hFFF, 1);
        drain();
        write_reg(REG_PROCESS, 32'hFFFF_FFFF);
        write_reg(REG_THREAD, 32'hFFFF_FFFF);
        write_reg(REG_CPU, 32'hFFF);
        send_event(32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 1);
        drain();
        write_reg(REG_PROCESS, 0);
        write_reg(REG_THREAD, 0);
        write_reg(REG_CPU, ANY_CPU);
        write_reg(REG_BANK, 1);

        // fill bank 1 to capacity under long back-pressure, then drops
        fork
            begin
                long_hold = 1;
                repeat (3000) @(posedge aclk);
                long_hold = 0;
            end
            for (int i = 0; i < 1024; i++)
                send_event(32'h9000, i, i[11:0], i[0]);
        join
        stall_free = 1;
        for (int i = 0; i < 8; i++) send_event(32'h9001, i, 0, i[0]);
        send_event(32'h9000, 5, 5, 1);
        stall_free = 0;
        drain();

        // random phases across configurations
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_BANK, ph[0] ? 1 : 0);
            case (ph % 4)
                0: begin
                    write_reg(REG_PROCESS, 0);
                    write_reg(REG_THREAD, 0);
                    write_reg(REG_CPU, ANY_CPU);
                end
                1: write_reg(REG_PROCESS, 32'h101);
                2: begin
                    write_reg(REG_PROCESS, 0);
                    write_reg(REG_CPU, 32'd2);
                end
                default: write_reg(REG_THREAD, 32'h203);
            endcase
            random_burst(12, 6);
            drain();
        end

        if (board.errors == 0 && board.exp_status.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

`default_nettype wire
